@@ rtl/ldsd_pkg.sv @@
`default_nettype none

package ldsd_pkg;

  localparam int unsigned HEADER_BYTES = 4;

  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_NINE  = 8'h39;
  localparam logic [7:0]  CK_SEED     = 8'h60;
  localparam logic [13:0] VERSION_MIN = 14'd201;
  localparam logic [7:0]  DIV10_MUL   = 8'd205;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SERIAL = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_SHOT_TOTAL   = 1'b0,
    CFG_KEYS_PRESENT = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] CI_SEED [256] = '{
    8'hc1,8'hbf,8'h6d,8'h0d,8'h59,8'hc5,8'h13,8'h9d,8'h83,8'h61,8'h6b,8'h4f,
    8'hc7,8'h7f,8'h3d,8'h3d,8'h53,8'h59,8'he3,8'hc7,8'he9,8'h2f,8'h95,8'ha7,
    8'h95,8'h1f,8'hdf,8'h7f,8'h2b,8'h29,8'hc7,8'h0d,8'hdf,8'h07,8'hef,8'h71,
    8'h89,8'h3d,8'h13,8'h3d,8'h3b,8'h13,8'hfb,8'h0d,8'h89,8'hc1,8'h65,8'h1f,
    8'hb3,8'h0d,8'h6b,8'h29,8'he3,8'hfb,8'hef,8'ha3,8'h6b,8'h47,8'h7f,8'h95,
    8'h35,8'ha7,8'h47,8'h4f,8'hc7,8'hf1,8'h59,8'h95,8'h35,8'h11,8'h29,8'h61,
    8'hf1,8'h3d,8'hb3,8'h2b,8'h0d,8'h43,8'h89,8'hc1,8'h9d,8'h9d,8'h89,8'h65,
    8'hf1,8'he9,8'hdf,8'hbf,8'h3d,8'h7f,8'h53,8'h97,8'he5,8'he9,8'h95,8'h17,
    8'h1d,8'h3d,8'h8b,8'hfb,8'hc7,8'he3,8'h67,8'ha7,8'h07,8'hf1,8'h71,8'ha7,
    8'h53,8'hb5,8'h29,8'h89,8'he5,8'h2b,8'ha7,8'h17,8'h29,8'he9,8'h4f,8'hc5,
    8'h65,8'h6d,8'h6b,8'hef,8'h0d,8'h89,8'h49,8'h2f,8'hb3,8'h43,8'h53,8'h65,
    8'h1d,8'h49,8'ha3,8'h13,8'h89,8'h59,8'hef,8'h6b,8'hef,8'h65,8'h1d,8'h0b,
    8'h59,8'h13,8'he3,8'h4f,8'h9d,8'hb3,8'h29,8'h43,8'h2b,8'h07,8'h1d,8'h95,
    8'h59,8'h59,8'h47,8'hfb,8'he5,8'he9,8'h61,8'h47,8'h2f,8'h35,8'h7f,8'h17,
    8'h7f,8'hef,8'h7f,8'h95,8'h95,8'h71,8'hd3,8'ha3,8'h0b,8'h71,8'ha3,8'had,
    8'h0b,8'h3b,8'hb5,8'hfb,8'ha3,8'hbf,8'h4f,8'h83,8'h1d,8'had,8'he9,8'h2f,
    8'h71,8'h65,8'ha3,8'he5,8'h07,8'h35,8'h3d,8'h0d,8'hb5,8'he9,8'he5,8'h47,
    8'h3b,8'h9d,8'hef,8'h35,8'ha3,8'hbf,8'hb3,8'hdf,8'h53,8'hd3,8'h97,8'h53,
    8'h49,8'h71,8'h07,8'h35,8'h61,8'h71,8'h2f,8'h43,8'h2f,8'h11,8'hdf,8'h17,
    8'h97,8'hfb,8'h95,8'h3b,8'h7f,8'h6b,8'hd3,8'h25,8'hbf,8'had,8'hc7,8'hc5,
    8'hc5,8'hb5,8'h8b,8'hef,8'h2f,8'hd3,8'h07,8'h6b,8'h25,8'h49,8'h95,8'h25,
    8'h49,8'h6d,8'h71,8'hc7
  };

  localparam logic [7:0] CJ_SEED [256] = '{
    8'ha7,8'hbc,8'hc9,8'had,8'h91,8'hdf,8'h85,8'he5,8'hd4,8'h78,8'hd5,8'h17,
    8'h46,8'h7c,8'h29,8'h4c,8'h4d,8'h03,8'he9,8'h25,8'h68,8'h11,8'h86,8'hb3,
    8'hbd,8'hf7,8'h6f,8'h61,8'h22,8'ha2,8'h26,8'h34,8'h2a,8'hbe,8'h1e,8'h46,
    8'h14,8'h68,8'h9d,8'h44,8'h18,8'hc2,8'h40,8'hf4,8'h7e,8'h5f,8'h1b,8'had,
    8'h0b,8'h94,8'hb6,8'h67,8'hb4,8'h0b,8'he1,8'hea,8'h95,8'h9c,8'h66,8'hdc,
    8'he7,8'h5d,8'h6c,8'h05,8'hda,8'hd5,8'hdf,8'h7a,8'hef,8'hf6,8'hdb,8'h1f,
    8'h82,8'h4c,8'hc0,8'h68,8'h47,8'ha1,8'hbd,8'hee,8'h39,8'h50,8'h56,8'h4a,
    8'hdd,8'hdf,8'ha5,8'hf8,8'hc6,8'hda,8'hca,8'h90,8'hca,8'h01,8'h42,8'h9d,
    8'h8b,8'h0c,8'h73,8'h43,8'h75,8'h05,8'h94,8'hde,8'h24,8'hb3,8'h80,8'h34,
    8'he5,8'h2c,8'hdc,8'h9b,8'h3f,8'hca,8'h33,8'h45,8'hd0,8'hdb,8'h5f,8'hf5,
    8'h52,8'hc3,8'h21,8'hda,8'he2,8'h22,8'h72,8'h6b,8'h3e,8'hd0,8'h5b,8'ha8,
    8'h87,8'h8c,8'h06,8'h5d,8'h0f,8'hdd,8'h09,8'h19,8'h93,8'hd0,8'hb9,8'hfc,
    8'h8b,8'h0f,8'h84,8'h60,8'h33,8'h1c,8'h9b,8'h45,8'hf1,8'hf0,8'ha3,8'h94,
    8'h3a,8'h12,8'h77,8'h33,8'h4d,8'h44,8'h78,8'h28,8'h3c,8'h9e,8'hfd,8'h65,
    8'h57,8'h16,8'h94,8'h6b,8'hfb,8'h59,8'hd0,8'hc8,8'h22,8'h36,8'hdb,8'hd2,
    8'h63,8'h98,8'h43,8'ha1,8'h04,8'h87,8'h86,8'hf7,8'ha6,8'h26,8'hbb,8'hd6,
    8'h59,8'h4d,8'hbf,8'h6a,8'h2e,8'haa,8'h2b,8'hef,8'he6,8'h78,8'hb6,8'h4e,
    8'he0,8'h2f,8'hdc,8'h7c,8'hbe,8'h57,8'h19,8'h32,8'h7e,8'h2a,8'hd0,8'hb8,
    8'hba,8'h29,8'h00,8'h3c,8'h52,8'h7d,8'ha8,8'h49,8'h3b,8'h2d,8'heb,8'h25,
    8'h49,8'hfa,8'ha3,8'haa,8'h39,8'ha7,8'hc5,8'ha7,8'h50,8'h11,8'h36,8'hfb,
    8'hc6,8'h67,8'h4a,8'hf5,8'ha5,8'h12,8'h65,8'h7e,8'hb0,8'hdf,8'haf,8'h4e,
    8'hb3,8'h61,8'h7f,8'h2f
  };

endpackage

`default_nettype wire

@@ rtl/lens_data_stream_decrypt_unit.sv @@
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tuser[1:0] command, tdata[7:0] value
// m_axis    out        tuser[0] was_decrypted, tdata[7:0] out_byte
// cfg       in         cfg_idx_i register index, cfg_data_i[31:0] write data
//
// One item per cycle; a data item shows its result in the cycle after acceptance.
// The keystream update is one 8x8 multiply-add per decrypted item, feeding cj_q.
// Start and serial items give no result; a held result stalls input only when
// m_axis_tready is low. Reset initialises the record state and config registers.
module lens_data_stream_decrypt_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output      logic        m_axis_tuser,   // [0] was_decrypted
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [2:0] HdrLen  = 3'(ldsd_pkg::HEADER_BYTES);
  localparam logic [2:0] HdrLast = 3'(ldsd_pkg::HEADER_BYTES - 1);

  logic [31:0] shutter_q;
  logic        keys_q;

  logic [7:0]  serial_acc_q, serial_acc_d;
  logic [13:0] version_q, version_d;
  logic        ver_open_q, ver_open_d;
  logic [2:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  ci_q, ci_d;
  logic [7:0]  cj_q, cj_d;
  logic [7:0]  ck_q, ck_d;
  logic        dec_on_q, dec_on_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_dec_q, out_dec_d;

  logic        accept;
  logic [7:0]  val;
  logic        is_digit;
  logic [15:0] div_prod;
  logic [4:0]  quot;
  logic [7:0]  rem;
  logic [3:0]  digit;
  logic [7:0]  key;
  logic [15:0] mul_prod;
  logic [7:0]  cj_step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign val           = s_axis_tdata;

  assign is_digit = (val >= ldsd_pkg::ASCII_ZERO) && (val <= ldsd_pkg::ASCII_NINE);
  assign div_prod = val * ldsd_pkg::DIV10_MUL;
  assign quot     = div_prod[15:11];
  assign rem      = val - (8'({quot, 3'b000}) + 8'({quot, 1'b0}));
  assign digit    = is_digit ? 4'(val - ldsd_pkg::ASCII_ZERO) : rem[3:0];

  assign key      = shutter_q[7:0] ^ shutter_q[15:8] ^ shutter_q[23:16] ^ shutter_q[31:24];
  assign mul_prod = ci_q * ck_q;
  assign cj_step  = cj_q + mul_prod[7:0];

  always_comb begin
    serial_acc_d = serial_acc_q;
    version_d    = version_q;
    ver_open_d   = ver_open_q;
    byte_idx_d   = byte_idx_q;
    ci_d         = ci_q;
    cj_d         = cj_q;
    ck_d         = ck_q;
    dec_on_d     = dec_on_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_byte_d   = out_byte_q;
    out_dec_d    = out_dec_q;

    if (accept) begin
      case (ldsd_pkg::cmd_e'(s_axis_tuser))
        ldsd_pkg::CMD_START: begin
          serial_acc_d = '0;
          version_d    = '0;
          ver_open_d   = 1'b1;
          byte_idx_d   = '0;
          ci_d         = '0;
          cj_d         = '0;
          ck_d         = ldsd_pkg::CK_SEED;
          dec_on_d     = 1'b0;
        end
        ldsd_pkg::CMD_SERIAL: begin
          serial_acc_d = 8'({serial_acc_q, 3'b000}) + 8'({serial_acc_q, 1'b0})
                       + {4'b0000, digit};
        end
        ldsd_pkg::CMD_DATA: begin
          out_valid_d = 1'b1;
          if (byte_idx_q < HdrLen) begin
            if (ver_open_q) begin
              if (is_digit) begin
                version_d = 14'({version_q, 3'b000}) + 14'({version_q, 1'b0})
                          + {10'b0, digit};
              end else begin
                ver_open_d = 1'b0;
              end
            end
            byte_idx_d = byte_idx_q + 3'd1;
            if (byte_idx_q == HdrLast) begin
              ci_d     = ldsd_pkg::CI_SEED[serial_acc_q];
              cj_d     = ldsd_pkg::CJ_SEED[key];
              ck_d     = ldsd_pkg::CK_SEED;
              dec_on_d = (version_d >= ldsd_pkg::VERSION_MIN) && keys_q;
            end
            out_byte_d = val;
            out_dec_d  = 1'b0;
          end else if (dec_on_q) begin
            cj_d       = cj_step;
            ck_d       = ck_q + 8'd1;
            out_byte_d = val ^ cj_step;
            out_dec_d  = 1'b1;
          end else begin
            out_byte_d = val;
            out_dec_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutter_q <= '0;
      keys_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (ldsd_pkg::cfg_idx_e'(cfg_idx_i))
        ldsd_pkg::CFG_SHOT_TOTAL:   shutter_q <= cfg_data_i;
        ldsd_pkg::CFG_KEYS_PRESENT: keys_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_acc_q <= '0;
      version_q    <= '0;
      ver_open_q   <= 1'b1;
      byte_idx_q   <= '0;
      ci_q         <= '0;
      cj_q         <= '0;
      ck_q         <= ldsd_pkg::CK_SEED;
      dec_on_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      serial_acc_q <= serial_acc_d;
      version_q    <= version_d;
      ver_open_q   <= ver_open_d;
      byte_idx_q   <= byte_idx_d;
      ci_q         <= ci_d;
      cj_q         <= cj_d;
      ck_q         <= ck_d;
      dec_on_q     <= dec_on_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_dec_q  <= out_dec_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_dec_q;

endmodule

`default_nettype wire
